/* hw/rtl/mmr_pkg.sv */
// Shared types, widths and register indexes for the 2x min/max restriction block.
// No dependencies; compile first.
package mmr_pkg;

  localparam int unsigned SampleW  = 32;
  localparam int unsigned MaxCw    = 1024;                 // deepest accumulator line
  localparam int unsigned XW       = $clog2(MaxCw);        // coarse column index
  localparam int unsigned ColW     = 11;                   // fine column counter
  localparam int unsigned RowW     = 17;                   // fine row counter
  localparam int unsigned CwW      = 11;                   // coarse_width register
  localparam int unsigned ChW      = 16;                   // coarse_height register
  localparam int unsigned YW       = 16;                   // coarse row index
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SELECT_MAX    = 2'd0,
    CFG_COARSE_WIDTH  = 2'd1,
    CFG_COARSE_HEIGHT = 2'd2
  } cfg_idx_t;

  // Control that travels with one horizontal reduction into the vertical stage.
  typedef struct packed {
    logic          odd_row;     // combine with current line, emit
    logic          first_row;   // no earlier row to merge
    logic          last_row;    // emit instead of storing
    logic          frame_last;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } vctl_t;

  // Max or min of two signed samples.
  function automatic sample_t pick(input logic sel_max, input sample_t a, input sample_t b);
    if (sel_max) begin
      return (a >= b) ? a : b;
    end
    return (a <= b) ? a : b;
  endfunction

endpackage

/* hw/rtl/mmr_in_if.sv */
// Request channel carrying fine-grid samples.
// Depends on mmr_pkg.
interface mmr_in_if;
  logic              valid;
  logic              ready;
  mmr_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* hw/rtl/mmr_out_if.sv */
// Result channel carrying coarse-grid values and their coordinates.
// Depends on mmr_pkg.
interface mmr_out_if;
  logic                       valid;
  logic                       ready;
  mmr_pkg::sample_t           coarse_value;
  logic [mmr_pkg::XW-1:0]     coarse_x;
  logic [mmr_pkg::YW-1:0]     coarse_y;
  logic                       frame_last;

  modport source (output valid, output coarse_value, output coarse_x, output coarse_y,
                  output frame_last, input ready);
  modport sink   (input valid, input coarse_value, input coarse_x, input coarse_y,
                  input frame_last, output ready);
endinterface

/* hw/rtl/monotone_minmax_restrict_2x_core.sv */
// Clipped 3x3 min/max pooling with stride 2 (2x restriction of a fine grid).
// Depends on mmr_pkg, mmr_in_if, mmr_out_if and mmr_ram.
//
// Usage:
//   in_chan  : fine samples of a (2W-1) x (2H-1) grid in raster order, one
//              request per valid/ready handshake.
//   out_chan : one coarse node per handshake in coarse raster order, with its
//              column, row and a frame_last flag on the final node.
//   cfg_*    : write select_max / coarse_width / coarse_height only while idle.
// Throughput is one sample per cycle while out_chan is not stalled. The sample
// completing a window loads the vertical stage register (horizontal reduction,
// accumulator read), then the vertical merge loads the output register.
// The rate is set by at most one read-modify-write per sample into the two
// 1024-entry accumulator RAMs (one read port, one write port each).
// Reset clears the counters, the horizontal carry, the configuration (max mode,
// 2 x 2 coarse grid) and all valids; the RAMs are not cleared, every entry is
// written before its read data is used in a frame. When the receiver stalls,
// the output register holds, a vertical stage item that would emit holds, the
// RAM read data stays registered, and in_chan.ready drops until space frees.
module monotone_minmax_restrict_2x_core (
  input  logic                           clk,
  input  logic                           rst_n,
  mmr_in_if.sink                         in_chan,
  mmr_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [mmr_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [mmr_pkg::CfgDataW-1:0]   cfg_wdata
);

  // Configuration registers.
  logic                      sel_max_r;
  logic [mmr_pkg::CwW-1:0]   cw_r;
  logic [mmr_pkg::ChW-1:0]   ch_r;

  // Front stage: fine position and horizontal carry.
  logic [mmr_pkg::ColW-1:0]  col_r, col_nxt;
  logic [mmr_pkg::RowW-1:0]  row_r, row_nxt;
  mmr_pkg::sample_t          carry_r, carry_nxt;

  // Vertical stage.
  logic                      s1_valid_r, s1_valid_nxt;
  mmr_pkg::sample_t          s1_h_r;
  mmr_pkg::vctl_t            s1_ctl_r, s1_ctl_nxt;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  mmr_pkg::sample_t          out_value_r;
  logic [mmr_pkg::XW-1:0]    out_x_r;
  logic [mmr_pkg::YW-1:0]    out_y_r;
  logic                      out_last_r;

  logic [mmr_pkg::CwW-1:0]   w_eff;
  logic [mmr_pkg::ChW-1:0]   h_eff;
  logic [mmr_pkg::CwW:0]     col_lim;
  logic [mmr_pkg::RowW-1:0]  row_lim;
  logic                      last_c, last_r;
  logic                      in_fire, have_h;
  mmr_pkg::sample_t          samp, hpick, h_val;

  mmr_pkg::sample_t          cur_rd, nxt_rd, v_val;
  logic                      s1_emit, s1_adv, out_free;
  logic                      cur_we, nxt_we;

  // Clamp the grid width to 2..MaxCw and raise the height to at least 2.
  always_comb begin
    if (cw_r < mmr_pkg::CwW'(2)) begin
      w_eff = mmr_pkg::CwW'(2);
    end else if (cw_r > mmr_pkg::CwW'(mmr_pkg::MaxCw)) begin
      w_eff = mmr_pkg::CwW'(mmr_pkg::MaxCw);
    end else begin
      w_eff = cw_r;
    end
    if (ch_r < mmr_pkg::ChW'(2)) begin
      h_eff = mmr_pkg::ChW'(2);
    end else begin
      h_eff = ch_r;
    end
  end

  assign col_lim = {w_eff, 1'b0} - (mmr_pkg::CwW+1)'(2);
  assign row_lim = {h_eff, 1'b0} - mmr_pkg::RowW'(2);
  assign last_c  = {1'b0, col_r} >= col_lim;
  assign last_r  = row_r >= row_lim;

  // Hold a request while the vertical stage cannot hand its item on.
  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_emit  = s1_ctl_r.odd_row || s1_ctl_r.last_row;
  assign s1_adv   = s1_valid_r && (!s1_emit || out_free);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign samp     = in_chan.sample;

  // Horizontal reduction: odd columns close a window, the last column closes the
  // clipped right-edge window.
  always_comb begin
    hpick  = mmr_pkg::pick(sel_max_r, carry_r, samp);
    have_h = col_r[0] || last_c;
    if (col_r[0] || (col_r == '0)) begin
      carry_nxt = samp;
    end else begin
      carry_nxt = hpick;
    end
    h_val = col_r[0] ? hpick : carry_nxt;
  end

  // Advance the fine position; wrap at row and frame end.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_c) begin
        col_nxt = '0;
        row_nxt = last_r ? '0 : row_r + mmr_pkg::RowW'(1);
      end else begin
        col_nxt = col_r + mmr_pkg::ColW'(1);
      end
    end
  end

  always_comb begin
    s1_ctl_nxt.odd_row    = row_r[0];
    s1_ctl_nxt.first_row  = (row_r == '0);
    s1_ctl_nxt.last_row   = last_r;
    s1_ctl_nxt.frame_last = last_c && last_r;
    s1_ctl_nxt.x          = col_r[mmr_pkg::XW:1];
    s1_ctl_nxt.y          = row_r[mmr_pkg::YW:1];
  end

  assign s1_valid_nxt = (in_fire && have_h) || (s1_valid_r && !s1_adv);

  // Both lines are read at the column of every horizontal result; the vertical
  // stage picks the one it needs. Consecutive requests never touch the same
  // column, so the write-back lands before the next read of that entry.
  mmr_ram #(
    .WIDTH (mmr_pkg::SampleW),
    .DEPTH (mmr_pkg::MaxCw)
  ) u_cur_line (
    .clk   (clk),
    .we    (cur_we),
    .waddr (s1_ctl_r.x),
    .wdata (v_val),
    .re    (in_fire && have_h),
    .raddr (s1_ctl_nxt.x),
    .rdata (cur_rd)
  );

  mmr_ram #(
    .WIDTH (mmr_pkg::SampleW),
    .DEPTH (mmr_pkg::MaxCw)
  ) u_next_line (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (s1_ctl_r.x),
    .wdata (s1_h_r),
    .re    (in_fire && have_h),
    .raddr (s1_ctl_nxt.x),
    .rdata (nxt_rd)
  );

  // Vertical merge: odd rows finish a window with the current line and park
  // their reduction in the next line; even rows seed the current line or emit.
  always_comb begin
    if (s1_ctl_r.odd_row) begin
      v_val = mmr_pkg::pick(sel_max_r, cur_rd, s1_h_r);
    end else if (s1_ctl_r.first_row) begin
      v_val = s1_h_r;
    end else begin
      v_val = mmr_pkg::pick(sel_max_r, nxt_rd, s1_h_r);
    end
    nxt_we = s1_adv && s1_ctl_r.odd_row;
    cur_we = s1_adv && !s1_ctl_r.odd_row && !s1_ctl_r.last_row;
  end

  assign out_valid_nxt = (s1_adv && s1_emit) || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_max_r   <= 1'b1;
      cw_r        <= mmr_pkg::CwW'(2);
      ch_r        <= mmr_pkg::ChW'(2);
      col_r       <= '0;
      row_r       <= '0;
      carry_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mmr_pkg::CFG_SELECT_MAX:    sel_max_r <= cfg_wdata[0];
          mmr_pkg::CFG_COARSE_WIDTH:  cw_r      <= cfg_wdata[mmr_pkg::CwW-1:0];
          mmr_pkg::CFG_COARSE_HEIGHT: ch_r      <= cfg_wdata[mmr_pkg::ChW-1:0];
          default: ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      if (in_fire) begin
        carry_r <= carry_nxt;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire && have_h) begin
      s1_h_r   <= h_val;
      s1_ctl_r <= s1_ctl_nxt;
    end
    if (s1_adv && s1_emit) begin
      out_value_r <= v_val;
      out_x_r     <= s1_ctl_r.x;
      out_y_r     <= s1_ctl_r.y;
      out_last_r  <= s1_ctl_r.frame_last;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.coarse_value = out_value_r;
  assign out_chan.coarse_x     = out_x_r;
  assign out_chan.coarse_y     = out_y_r;
  assign out_chan.frame_last   = out_last_r;

endmodule

/* hw/rtl/mmr_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module mmr_ram #(
  parameter  int unsigned WIDTH  = 32,
  parameter  int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
